>>> design/easter_movable_feast_dates_assert.svh
// Assertion macros used by the checker file.
// Clock clk_i and active-low reset rst_ni are taken from the scope of use.
`ifndef EASTER_MOVABLE_FEAST_DATES_ASSERT_SVH
`define EASTER_MOVABLE_FEAST_DATES_ASSERT_SVH

// Same-cycle implication
`define EMFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/emfd_pkg.sv
package emfd_pkg;

  localparam int YEAR_W  = 14;
  localparam int FEAST_W = 3;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;

  // Feast codes, in the order the beats leave the block
  localparam logic [FEAST_W-1:0] FEAST_EASTER   = 3'd0;
  localparam logic [FEAST_W-1:0] FEAST_CARN_BEG = 3'd1;
  localparam logic [FEAST_W-1:0] FEAST_CARN_END = 3'd2;
  localparam logic [FEAST_W-1:0] FEAST_GOOD_FRI = 3'd3;
  localparam logic [FEAST_W-1:0] FEAST_ASCENSION = 3'd4;
  localparam logic [FEAST_W-1:0] FEAST_WHITSUN  = 3'd5;

  // Day offset of each feast from Easter Sunday
  function automatic logic signed [DOY_W:0] feast_offset(input logic [FEAST_W-1:0] feast);
    logic signed [DOY_W:0] off;
    unique case (feast)
      FEAST_EASTER:    off = 10'sd0;
      FEAST_CARN_BEG:  off = -10'sd49;
      FEAST_CARN_END:  off = -10'sd47;
      FEAST_GOOD_FRI:  off = -10'sd2;
      FEAST_ASCENSION: off = 10'sd39;
      FEAST_WHITSUN:   off = 10'sd49;
      default:         off = 10'sd0;
    endcase
    return off;
  endfunction

  // Days of the year that come before the first of the given month
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                   input logic leap);
    logic [DOY_W-1:0] lp;
    logic [DOY_W-1:0] days;
    lp = DOY_W'(leap);
    unique case (mon)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59 + lp;
      4'd4:    days = 9'd90 + lp;
      4'd5:    days = 9'd120 + lp;
      4'd6:    days = 9'd151 + lp;
      4'd7:    days = 9'd181 + lp;
      4'd8:    days = 9'd212 + lp;
      4'd9:    days = 9'd243 + lp;
      4'd10:   days = 9'd273 + lp;
      4'd11:   days = 9'd304 + lp;
      4'd12:   days = 9'd334 + lp;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

>>> design/easter_movable_feast_dates.sv
// Movable feasts of a Gregorian year. One year beat in gives six result beats out, in order
// Easter Sunday, carnival start, carnival end, Good Friday, Ascension and Whitsun, the sixth
// flagged by last_o; years outside 1583..9999 are clamped to that range. The computus runs
// in a twelve-stage pipeline that takes a new year in any cycle in which a stage has room,
// and each year passes from the last stage through the sequencer register and the output
// register before its first result beat shows. The result port carries one feast a beat,
// so the six-beat sequencer takes the next year only once the held year's last beat goes
// out; a stall on the result side holds every full stage and fills any bubbles behind it.
module easter_movable_feast_dates
  import emfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [YEAR_W-1:0]  year_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FEAST_W-1:0] feast_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [DAY_W-1:0]   day_o,
  output logic               last_o
);

  localparam int NUM_STAGES = 12;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // Reciprocals for constant division, exact over the clamped ranges
  localparam logic [12:0] RCP100 = 13'd5243;   // >> 19
  localparam logic [13:0] RCP19  = 14'd13798;  // >> 18
  localparam logic [5:0]  RCP25  = 6'd41;      // >> 10
  localparam logic [7:0]  RCP3   = 8'd171;     // >> 9
  localparam logic [10:0] RCP30  = 11'd1093;   // >> 15
  localparam logic [5:0]  RCP7   = 6'd37;      // >> 8

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;
  logic                  seq_take;

  // Stage registers
  logic [YEAR_W-1:0] y0_q, y1_q;
  logic [6:0] q100_1_q;
  logic [9:0] q19_1_q;
  logic [4:0] a2_q, a3_q, a4_q, a5_q, a6_q, a7_q, a8_q, a9_q, a10_q;
  logic [6:0] b2_q, b3_q, b4_q, c2_q;
  logic       yz2_q;
  logic [4:0] d3_q, d4_q, i3_q, i4_q, i5_q, i6_q, i7_q;
  logic [1:0] e3_q, e4_q, e5_q, e6_q, e7_q, k3_q, k4_q, k5_q, k6_q, k7_q;
  logic [2:0] f3_q;
  logic       leap3_q, leap4_q, leap5_q, leap6_q, leap7_q, leap8_q, leap9_q, leap10_q;
  logic       leap11_q;
  logic [5:0] g4_q;
  logic [8:0] hx5_q, hx6_q;
  logic [3:0] q30_6_q;
  logic [4:0] h7_q, h8_q, h9_q, h10_q;
  logic [6:0] lx8_q, lx9_q;
  logic [3:0] q7_9_q;
  logic [2:0] l10_q;
  logic [DOY_W-1:0] doy11_q;

  // Next values of the computing stages
  logic [YEAR_W-1:0] y0_d;
  logic [6:0] q100_1_d;
  logic [9:0] q19_1_d;
  logic [4:0] a2_d;
  logic [6:0] c2_d;
  logic       yz2_d;
  logic [2:0] f3_d;
  logic       leap3_d;
  logic [5:0] g4_d;
  logic [8:0] hx5_d;
  logic [3:0] q30_6_d;
  logic [4:0] h7_d;
  logic [6:0] lx8_d;
  logic [3:0] q7_9_d;
  logic [2:0] l10_d;
  logic [DOY_W-1:0] doy11_d;

  logic [25:0] p100;
  logic [27:0] p19;
  logic [13:0] diff19, diff100;
  logic [12:0] fx;
  logic [14:0] gx;
  logic [9:0]  hsum;
  logic [18:0] qx30;
  logic [8:0]  hrem;
  logic [7:0]  lsum;
  logic [11:0] qx7;
  logic [6:0]  lrem;
  logic [8:0]  msum;
  logic        m_hi;
  logic [7:0]  base;

  // Sequencer and output register
  logic               seq_v_q;
  logic [FEAST_W-1:0] seq_cnt_q;
  logic [DOY_W-1:0]   seq_doy_q;
  logic               seq_leap_q;
  logic               out_valid_q;
  logic [FEAST_W-1:0] feast_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;
  logic               last_q;
  logic               out_load;
  logic               seq_last;

  logic signed [DOY_W:0] t_s;
  logic [DOY_W-1:0]      rem;
  logic [DOY_W-1:0]      day_full;
  logic [MONTH_W-1:0]    month_d;
  logic [DAY_W-1:0]      day_d;

  // Advance a stage when it or any stage downstream has room, or when the sequencer takes a year
  assign out_load = !out_valid_q || !out_stall_i;
  assign seq_last = (seq_cnt_q == FEAST_WHITSUN);
  assign seq_take = !seq_v_q || (out_load && seq_last);

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      en[k] = seq_take ||
              (~(vld_q | NUM_STAGES'((1 << k) - 1)) != '0);
    end
  end

  assign in_stall_o = !en[0];

  // Clamp the year to the Gregorian range
  always_comb begin
    if (year_i < YEAR_MIN) begin
      y0_d = YEAR_MIN;
    end else if (year_i > YEAR_MAX) begin
      y0_d = YEAR_MAX;
    end else begin
      y0_d = year_i;
    end
  end

  // Computus arithmetic, one slice per stage
  always_comb begin
    p100     = 26'(y0_q) * 26'(RCP100);
    q100_1_d = p100[25:19];
    p19      = 28'(y0_q) * 28'(RCP19);
    q19_1_d  = p19[27:18];

    diff19  = y1_q - 14'(q19_1_q) * 14'd19;
    diff100 = y1_q - 14'(q100_1_q) * 14'd100;
    a2_d    = diff19[4:0];
    c2_d    = diff100[6:0];
    yz2_d   = (y1_q[1:0] == 2'b00);

    fx      = (13'(b2_q) + 13'd8) * 13'(RCP25);
    f3_d    = fx[12:10];
    leap3_d = yz2_q && !((c2_q == 7'd0) && (b2_q[1:0] != 2'b00));

    gx   = (15'(b3_q) - 15'(f3_q) + 15'd1) * 15'(RCP3);
    g4_d = gx[14:9];

    hsum  = 10'(a4_q) * 10'd19 + 10'(b4_q) - 10'(d4_q) - 10'(g4_q) + 10'd15;
    hx5_d = hsum[8:0];

    qx30    = 19'(hx5_q) * 19'(RCP30);
    q30_6_d = qx30[18:15];

    hrem = hx6_q - 9'(q30_6_q) * 9'd30;
    h7_d = hrem[4:0];

    lsum  = 8'd32 + 8'({e7_q, 1'b0}) + 8'({i7_q, 1'b0}) - 8'(h7_q) - 8'(k7_q);
    lx8_d = lsum[6:0];

    qx7    = 12'(lx8_q) * 12'(RCP7);
    q7_9_d = qx7[11:8];

    lrem  = lx9_q - 7'(q7_9_q) * 7'd7;
    l10_d = lrem[2:0];

    // Base value and day of year; March and April fold into one offset
    msum    = 9'(a10_q) + 9'(h10_q) * 9'd11 + 9'(l10_q) * 9'd22;
    m_hi    = (msum >= 9'd451);
    base    = 8'(h10_q) + 8'(l10_q) + 8'd114 - (m_hi ? 8'd7 : 8'd0);
    doy11_d = 9'(base) - 9'd33 + 9'(leap10_q);
  end

  // Shift valid bits where a stage advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (en & {vld_q[NUM_STAGES-2:0], in_valid_i}) | (~en & vld_q);
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      y0_q <= y0_d;
    end
    if (en[1]) begin
      y1_q     <= y0_q;
      q100_1_q <= q100_1_d;
      q19_1_q  <= q19_1_d;
    end
    if (en[2]) begin
      a2_q  <= a2_d;
      b2_q  <= q100_1_q;
      c2_q  <= c2_d;
      yz2_q <= yz2_d;
    end
    if (en[3]) begin
      a3_q    <= a2_q;
      b3_q    <= b2_q;
      d3_q    <= b2_q[6:2];
      e3_q    <= b2_q[1:0];
      f3_q    <= f3_d;
      i3_q    <= c2_q[6:2];
      k3_q    <= c2_q[1:0];
      leap3_q <= leap3_d;
    end
    if (en[4]) begin
      a4_q    <= a3_q;
      b4_q    <= b3_q;
      d4_q    <= d3_q;
      g4_q    <= g4_d;
      e4_q    <= e3_q;
      i4_q    <= i3_q;
      k4_q    <= k3_q;
      leap4_q <= leap3_q;
    end
    if (en[5]) begin
      hx5_q   <= hx5_d;
      a5_q    <= a4_q;
      e5_q    <= e4_q;
      i5_q    <= i4_q;
      k5_q    <= k4_q;
      leap5_q <= leap4_q;
    end
    if (en[6]) begin
      hx6_q   <= hx5_q;
      q30_6_q <= q30_6_d;
      a6_q    <= a5_q;
      e6_q    <= e5_q;
      i6_q    <= i5_q;
      k6_q    <= k5_q;
      leap6_q <= leap5_q;
    end
    if (en[7]) begin
      h7_q    <= h7_d;
      a7_q    <= a6_q;
      e7_q    <= e6_q;
      i7_q    <= i6_q;
      k7_q    <= k6_q;
      leap7_q <= leap6_q;
    end
    if (en[8]) begin
      lx8_q   <= lx8_d;
      h8_q    <= h7_q;
      a8_q    <= a7_q;
      leap8_q <= leap7_q;
    end
    if (en[9]) begin
      lx9_q   <= lx8_q;
      q7_9_q  <= q7_9_d;
      h9_q    <= h8_q;
      a9_q    <= a8_q;
      leap9_q <= leap8_q;
    end
    if (en[10]) begin
      l10_q    <= l10_d;
      h10_q    <= h9_q;
      a10_q    <= a9_q;
      leap10_q <= leap9_q;
    end
    if (en[11]) begin
      doy11_q  <= doy11_d;
      leap11_q <= leap10_q;
    end
  end

  // Turn the current feast's day of year into month and day
  always_comb begin
    t_s = $signed({1'b0, seq_doy_q}) + feast_offset(seq_cnt_q);
    rem = (t_s < 10'sd1) ? 9'd1 : t_s[DOY_W-1:0];
    month_d = 4'd1;
    for (int j = 2; j <= 12; j++) begin
      if (rem > month_start(MONTH_W'(j), seq_leap_q)) begin
        month_d = MONTH_W'(j);
      end
    end
    day_full = rem - month_start(month_d, seq_leap_q);
    day_d    = (day_full > 9'd31) ? 5'd31 : day_full[DAY_W-1:0];
  end

  // Step through the six feasts of the held year
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_v_q   <= 1'b0;
      seq_cnt_q <= FEAST_EASTER;
    end else begin
      if (seq_take) begin
        seq_v_q   <= vld_q[NUM_STAGES-1];
        seq_cnt_q <= FEAST_EASTER;
      end else if (out_load) begin
        seq_cnt_q <= seq_cnt_q + FEAST_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take) begin
      seq_doy_q  <= doy11_q;
      seq_leap_q <= leap11_q;
    end
  end

  // Output register: load a beat whenever the slot is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= seq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && seq_v_q) begin
      feast_q <= seq_cnt_q;
      month_q <= month_d;
      day_q   <= day_d;
      last_q  <= seq_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign feast_o     = feast_q;
  assign month_o     = month_q;
  assign day_o       = day_q;
  assign last_o      = last_q;

endmodule

>>> design/emfd_checker.sv
`include "easter_movable_feast_dates_assert.svh"

module emfd_checker
  import emfd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [FEAST_W-1:0] feast_o,
  input logic [MONTH_W-1:0] month_o,
  input logic [DAY_W-1:0]   day_o,
  input logic               last_o
);

  // Hold a stalled beat
  `EMFD_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(feast_o) && $stable(month_o) && $stable(day_o) && $stable(last_o), "stalled result beat changed")

  // Follow a taken feast straight away with the next one of the same year
  `EMFD_ASSERT_NEXT(a_feast_step, out_valid_o && !out_stall_i && !last_o, out_valid_o && (feast_o == $past(feast_o) + FEAST_W'(1)), "feast sequence broken")

  // Flag the final feast only
  `EMFD_ASSERT_NOW(a_last_flag, out_valid_o, last_o == (feast_o == FEAST_WHITSUN), "last flag does not match feast")

  // Open a new year with Easter
  `EMFD_ASSERT_NOW(a_year_start, (out_valid_o && !out_stall_i && last_o) ##1 out_valid_o, feast_o == FEAST_EASTER, "new year does not start with Easter")

  // Keep dates in calendar range
  `EMFD_ASSERT_NOW(a_date_range, out_valid_o, (month_o >= 4'd1) && (month_o <= 4'd12) && (day_o >= 5'd1), "date out of range")

endmodule

bind easter_movable_feast_dates emfd_checker u_emfd_checker (.*);
